// File: sv/nmf_pkg.sv
// Shared types and constants of the Nagao-Matsuyama filter
`timescale 1ns / 1ps
package nmf_pkg;
  localparam int NUM_MASKS = 9;
  localparam int WIN       = 5;
  localparam int HELD_COLS = 4;
  localparam int WIN_PIX   = WIN * WIN;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 8;

  // Row bitmaps, bit 0 = oldest column; mask 0 is the 3x3 centre.
  localparam logic [WIN-1:0] MASK_ROWS [NUM_MASKS][WIN] = '{
    '{5'h00, 5'h0E, 5'h0E, 5'h0E, 5'h00},
    '{5'h0E, 5'h0E, 5'h04, 5'h00, 5'h00},
    '{5'h18, 5'h1C, 5'h0C, 5'h00, 5'h00},
    '{5'h00, 5'h18, 5'h1C, 5'h18, 5'h00},
    '{5'h00, 5'h00, 5'h0C, 5'h1C, 5'h18},
    '{5'h00, 5'h00, 5'h04, 5'h0E, 5'h0E},
    '{5'h00, 5'h00, 5'h06, 5'h07, 5'h03},
    '{5'h00, 5'h03, 5'h07, 5'h03, 5'h00},
    '{5'h03, 5'h07, 5'h06, 5'h00, 5'h00}
  };

  localparam int CENTRE_SIZE = 9;
  localparam int WEDGE_SIZE  = 7;

  typedef struct packed {
    logic sum_en;
    logic var_en;
  } lane_ctl_t;
endpackage

// File: sv/nmf_in_if.sv
// Column input channel
`timescale 1ns / 1ps
interface nmf_in_if;
  logic                     valid;
  logic                     ready;
  logic [nmf_pkg::IN_W-1:0] row_m2;
  logic [nmf_pkg::IN_W-1:0] row_m1;
  logic [nmf_pkg::IN_W-1:0] row_c;
  logic [nmf_pkg::IN_W-1:0] row_p1;
  logic [nmf_pkg::IN_W-1:0] row_p2;
  logic                     first_in_row;
  modport source (output valid, row_m2, row_m1, row_c, row_p1, row_p2, first_in_row,
                  input ready);
  modport sink (input valid, row_m2, row_m1, row_c, row_p1, row_p2, first_in_row,
                output ready);
endinterface

// File: sv/nmf_out_if.sv
// Filtered pixel output channel
`timescale 1ns / 1ps
interface nmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [nmf_pkg::OUT_W-1:0] filtered_pixel;
  modport source (output valid, filtered_pixel, input ready);
  modport sink (input valid, filtered_pixel, output ready);
endinterface

// File: sv/nmf_lane.sv
// One mask lane: sum, sum of squares and scaled variance
`timescale 1ns / 1ps
module nmf_lane #(
  parameter int PW   = 8,
  parameter int MASK = 0
) (
  input  logic                                      clk,
  input  nmf_pkg::lane_ctl_t                        ctl,
  input  logic [nmf_pkg::WIN_PIX-1:0][PW-1:0]       pix,
  input  logic [nmf_pkg::WIN_PIX-1:0][2*PW-1:0]     sqr,
  output logic [PW+3:0]                             sum,
  output logic [2*PW+7:0]                           num
);
  localparam int SW = PW + 4;
  localparam int QW = 2 * PW + 4;
  localparam int NW = 2 * PW + 8;
  localparam int N  = (MASK == 0) ? nmf_pkg::CENTRE_SIZE : nmf_pkg::WEDGE_SIZE;

  logic [SW-1:0] s_nxt, s_r;
  logic [QW-1:0] q_nxt, q_r;
  logic [NW-1:0] num_r;

  always_comb begin
    s_nxt = '0;
    q_nxt = '0;
    for (int r = 0; r < nmf_pkg::WIN; r++) begin
      for (int c = 0; c < nmf_pkg::WIN; c++) begin
        if (nmf_pkg::MASK_ROWS[MASK][r][c]) begin
          s_nxt = s_nxt + SW'(pix[r*nmf_pkg::WIN+c]);
          q_nxt = q_nxt + QW'(sqr[r*nmf_pkg::WIN+c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      s_r <= s_nxt;
      q_r <= q_nxt;
    end
    if (ctl.var_en) begin
      num_r <= NW'(q_r) * NW'(N) - NW'(s_r) * NW'(s_r);
    end
  end

  assign sum = s_r;
  assign num = num_r;
endmodule

// File: sv/nmf_merge.sv
// Minimum-variance scan over the lanes, mean division and output register
`timescale 1ns / 1ps
module nmf_merge #(
  parameter int PW = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [nmf_pkg::NUM_MASKS-1:0][PW+3:0]    sums,
  input  logic [nmf_pkg::NUM_MASKS-1:0][2*PW+7:0]  nums,
  output logic                                     busy,
  nmf_out_if.source                                out_ch
);
  localparam int SW = PW + 4;
  localparam int NW = 2 * PW + 8;
  localparam int KW = NW + 7;
  localparam int K  = SW + 4;
  localparam logic [K-1:0] R9 = K'((2**K + nmf_pkg::CENTRE_SIZE - 1) / nmf_pkg::CENTRE_SIZE);
  localparam logic [K-1:0] R7 = K'((2**K + nmf_pkg::WEDGE_SIZE - 1) / nmf_pkg::WEDGE_SIZE);
  localparam logic [3:0] LAST = 4'(nmf_pkg::NUM_MASKS - 1);

  typedef enum logic [1:0] {M_IDLE, M_SCAN, M_MUL, M_PUT} mstate_t;

  mstate_t                   state_r;
  logic [3:0]                idx_r;
  logic [KW-1:0]             best_key_r;
  logic [SW-1:0]             best_sum_r;
  logic                      best_ctr_r;
  logic [SW+K-1:0]           prod_r;
  logic                      out_valid_r;
  logic [nmf_pkg::OUT_W-1:0] out_data_r;
  logic [KW-1:0]             key;
  logic                      take;
  logic                      out_free;

  // Compare num/n^2 across sizes by scaling with the other mask's square.
  always_comb begin
    if (idx_r == '0) begin
      key = KW'(nums[idx_r]) * KW'(nmf_pkg::WEDGE_SIZE * nmf_pkg::WEDGE_SIZE);
    end else begin
      key = KW'(nums[idx_r]) * KW'(nmf_pkg::CENTRE_SIZE * nmf_pkg::CENTRE_SIZE);
    end
    take     = (idx_r == '0) || (key < best_key_r);
    out_free = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != M_PUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            idx_r   <= '0;
            state_r <= M_SCAN;
          end
        end
        M_SCAN: begin
          if (take) begin
            best_key_r <= key;
            best_sum_r <= sums[idx_r];
            best_ctr_r <= (idx_r == '0);
          end
          if (idx_r == LAST) begin
            state_r <= M_MUL;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        M_MUL: begin
          prod_r  <= (SW+K)'(best_sum_r) * (SW+K)'(best_ctr_r ? R9 : R7);
          state_r <= M_PUT;
        end
        M_PUT: begin
          if (out_free) begin
            out_data_r  <= nmf_pkg::OUT_W'(prod_r[K +: PW]);
            out_valid_r <= 1'b1;
            state_r     <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign busy                  = (state_r != M_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_pixel = out_data_r;
endmodule

// File: sv/nagao_matsuyama_filter_top.sv
// Top level of the streaming 5x5 Nagao-Matsuyama edge-preserving filter
`timescale 1ns / 1ps
// One beat carries a five-pixel column; the block holds the four earlier columns of the row
// and, from the fifth column on, returns the mean of the least-variance mask of nine. A column
// that yields no result leaves the block idle and ready for the next beat. A column that yields
// a result passes, in order, through taking the beat, squaring, lane sums, lane variance, the
// start of the merge unit, a scan of the lane variances one per cycle, a division of the
// winning sum by a reciprocal multiply and the load of the output register; the merge unit
// then returns to idle before the next beat is taken. A finished pixel waits in the
// output register while the next column is taken; while it is still unaccepted, the next
// result holds in the merge unit and the input stalls.
module nagao_matsuyama_filter_top #(
  parameter int PIXEL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  nmf_in_if.sink    in_ch,
  nmf_out_if.source out_ch
);
  localparam int PW = (PIXEL_BITS < nmf_pkg::IN_W) ? PIXEL_BITS : nmf_pkg::IN_W;
  localparam int SW = PW + 4;
  localparam int NW = 2 * PW + 8;
  localparam int NP = nmf_pkg::WIN_PIX;
  localparam int HP = nmf_pkg::HELD_COLS * nmf_pkg::WIN;
  localparam logic [2:0] FULL = 3'(nmf_pkg::HELD_COLS);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_VAR, S_MRG} state_t;

  state_t                                   state_r;
  logic [2:0]                               seen_r;
  logic                                     start_r;
  logic [HP-1:0][PW-1:0]                    hist_r;
  logic [NP-1:0][PW-1:0]                    win_r;
  logic [NP-1:0][2*PW-1:0]                  sqr_r;
  logic [nmf_pkg::WIN-1:0][PW-1:0]          col;
  logic [2:0]                               seen;
  logic                                     accept;
  logic                                     merge_busy;
  nmf_pkg::lane_ctl_t                       ctl;
  logic [nmf_pkg::NUM_MASKS-1:0][SW-1:0]    sums;
  logic [nmf_pkg::NUM_MASKS-1:0][NW-1:0]    nums;

  always_comb begin
    col[0]     = in_ch.row_m2[PW-1:0];
    col[1]     = in_ch.row_m1[PW-1:0];
    col[2]     = in_ch.row_c[PW-1:0];
    col[3]     = in_ch.row_p1[PW-1:0];
    col[4]     = in_ch.row_p2[PW-1:0];
    seen       = in_ch.first_in_row ? 3'd0 : seen_r;
    accept     = in_ch.valid && (state_r == S_IDLE);
    ctl.sum_en = (state_r == S_SUM);
    ctl.var_en = (state_r == S_VAR);
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= '0;
      start_r <= 1'b0;
      hist_r  <= '0;
    end else begin
      start_r <= (state_r == S_VAR);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            // window index is row * WIN + column, column 4 = current
            for (int r = 0; r < nmf_pkg::WIN; r++) begin
              for (int c = 0; c < nmf_pkg::HELD_COLS; c++) begin
                win_r[r*nmf_pkg::WIN+c] <= hist_r[c*nmf_pkg::WIN+r];
              end
              win_r[r*nmf_pkg::WIN+nmf_pkg::HELD_COLS] <= col[r];
            end
            for (int r = 0; r < nmf_pkg::WIN; r++) begin
              for (int c = 0; c < nmf_pkg::HELD_COLS - 1; c++) begin
                hist_r[c*nmf_pkg::WIN+r] <= hist_r[(c+1)*nmf_pkg::WIN+r];
              end
              hist_r[(nmf_pkg::HELD_COLS-1)*nmf_pkg::WIN+r] <= col[r];
            end
            seen_r <= (seen < FULL) ? seen + 3'd1 : seen;
            if (seen >= FULL) begin
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          for (int i = 0; i < NP; i++) begin
            sqr_r[i] <= (2*PW)'(win_r[i]) * (2*PW)'(win_r[i]);
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          state_r <= S_VAR;
        end
        S_VAR: begin
          state_r <= S_MRG;
        end
        S_MRG: begin
          if (!start_r && !merge_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  for (genvar m = 0; m < nmf_pkg::NUM_MASKS; m++) begin : g_lane
    nmf_lane #(.PW(PW), .MASK(m)) u_lane (
      .clk (clk),
      .ctl (ctl),
      .pix (win_r),
      .sqr (sqr_r),
      .sum (sums[m]),
      .num (nums[m])
    );
  end

  nmf_merge #(.PW(PW)) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .sums   (sums),
    .nums   (nums),
    .busy   (merge_busy),
    .out_ch (out_ch)
  );
endmodule
